// ----- rtl/stree_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stree_pkg
// Shared types and constants of the segment tree range-sum core.
// ----------------------------------------------------------------------------
package stree_pkg;

	// Fixed widths of the item fields.
	localparam int IDX_W = 10;
	localparam int VAL_W = 16;
	localparam int OUT_W = 26;

	// Largest total that a result item can carry; larger sums saturate to it.
	localparam logic [OUT_W-1:0] TOTAL_MAX = {OUT_W{1'b1}};

	// Item kinds.
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_UPD_LEAF,
		S_UPD_UP,
		S_QRY,
		S_QFIN
	} stree_state_t;

	// Status from the sequencer to the top level.
	typedef struct packed {
		logic take_ready;   // sequencer can take an input item
		logic result_load;  // a finished total is ready for the output register
	} stree_stat_t;

endpackage

`default_nettype wire

// ----- rtl/stree_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stree_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module stree_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/stree_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stree_ctrl
// Sequencer of the segment tree: clears the node memory after reset, walks an
// update from leaf to root and gathers a query bottom-up, one access a cycle.
// ----------------------------------------------------------------------------
module stree_ctrl #(
	parameter int LEAF_COUNT = 1024,
	parameter int NIDX_W     = $clog2(2 * LEAF_COUNT),
	parameter int NODE_W     = stree_pkg::VAL_W + $clog2(LEAF_COUNT)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          kind,
	input  wire logic [stree_pkg::IDX_W-1:0]   leaf_index,
	input  wire logic [stree_pkg::VAL_W-1:0]   leaf_value,
	input  wire logic [stree_pkg::IDX_W-1:0]   range_first,
	input  wire logic [stree_pkg::IDX_W-1:0]   range_last,
	input  wire logic                          out_free,
	output stree_pkg::stree_stat_t             stat,
	output logic      [stree_pkg::OUT_W-1:0]   total,
	output logic                               ram_we,
	output logic      [NIDX_W-1:0]             ram_waddr,
	output logic      [NODE_W-1:0]             ram_wdata,
	output logic      [NIDX_W-1:0]             ram_raddr,
	input  wire logic [NODE_W-1:0]             ram_rdata
);

	// Pointers can reach 2*LEAF_COUNT, one past the last node.
	localparam int PTR_W = NIDX_W + 1;
	localparam int EXT_W = (PTR_W > stree_pkg::IDX_W) ? PTR_W : stree_pkg::IDX_W;
	localparam int ACC_W = (NODE_W > stree_pkg::OUT_W) ? NODE_W : stree_pkg::OUT_W;
	localparam logic [EXT_W-1:0]  LEAF_EXT  = EXT_W'(LEAF_COUNT);
	localparam logic [PTR_W-1:0]  LEAF_BASE = PTR_W'(LEAF_COUNT);
	localparam logic [NIDX_W-1:0] LAST_NODE = NIDX_W'(2 * LEAF_COUNT - 1);
	localparam logic [NIDX_W-1:0] ROOT_NODE = NIDX_W'(1);

	stree_pkg::stree_state_t state_q, state_d;

	logic [NIDX_W-1:0] clr_q;
	logic [NIDX_W-1:0] cur_q;
	logic [NODE_W-1:0] curv_q;
	logic [PTR_W-1:0]  lo_q;
	logic [PTR_W-1:0]  hi_q;
	logic [ACC_W-1:0]  total_q;
	logic              pend_q;

	logic [EXT_W-1:0]  idx_ext;
	logic [EXT_W-1:0]  first_ext;
	logic [EXT_W-1:0]  last_clamp;
	logic              idx_ok;
	logic              q_nonempty;
	logic              lo_lt_hi;
	logic              rd_lo;
	logic              rd_hi;
	logic [PTR_W-1:0]  hi_m1;
	logic [NODE_W-1:0] up_sum;

	// Decode of the incoming item and of the query walk.
	always_comb begin
		idx_ext    = EXT_W'(leaf_index);
		first_ext  = EXT_W'(range_first);
		last_clamp = (EXT_W'(range_last) >= LEAF_EXT) ? (LEAF_EXT - EXT_W'(1))
		                                               : EXT_W'(range_last);
		idx_ok     = idx_ext < LEAF_EXT;
		q_nonempty = first_ext <= last_clamp;
		lo_lt_hi   = lo_q < hi_q;
		rd_lo      = lo_lt_hi && lo_q[0];
		rd_hi      = lo_lt_hi && !lo_q[0] && hi_q[0];
		hi_m1      = hi_q - PTR_W'(1);
		up_sum     = curv_q + ram_rdata;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stree_pkg::S_CLEAR: begin
				if (clr_q == LAST_NODE) begin
					state_d = stree_pkg::S_IDLE;
				end
			end
			stree_pkg::S_IDLE: begin
				if (in_valid) begin
					if (kind == stree_pkg::KIND_QUERY) begin
						state_d = q_nonempty ? stree_pkg::S_QRY : stree_pkg::S_QFIN;
					end else if (idx_ok) begin
						state_d = stree_pkg::S_UPD_LEAF;
					end
				end
			end
			stree_pkg::S_UPD_LEAF: begin
				state_d = stree_pkg::S_UPD_UP;
			end
			stree_pkg::S_UPD_UP: begin
				if (cur_q == ROOT_NODE) begin
					state_d = stree_pkg::S_IDLE;
				end
			end
			stree_pkg::S_QRY: begin
				if (!lo_lt_hi) begin
					state_d = stree_pkg::S_QFIN;
				end
			end
			stree_pkg::S_QFIN: begin
				if (out_free) begin
					state_d = stree_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = stree_pkg::S_IDLE;
			end
		endcase
	end

	// Memory controls and status.
	always_comb begin
		ram_we           = 1'b0;
		ram_waddr        = cur_q;
		ram_wdata        = curv_q;
		ram_raddr        = cur_q ^ NIDX_W'(1);
		stat.take_ready  = 1'b0;
		stat.result_load = 1'b0;
		unique case (state_q)
			stree_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			stree_pkg::S_IDLE: begin
				stat.take_ready = 1'b1;
			end
			stree_pkg::S_UPD_LEAF: begin
				ram_we = 1'b1;
			end
			stree_pkg::S_UPD_UP: begin
				ram_we    = 1'b1;
				ram_wdata = up_sum;
			end
			stree_pkg::S_QRY: begin
				ram_raddr = rd_hi ? hi_m1[NIDX_W-1:0] : lo_q[NIDX_W-1:0];
			end
			stree_pkg::S_QFIN: begin
				stat.result_load = out_free;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Saturate the gathered sum to the result width.
	assign total = (total_q > ACC_W'(stree_pkg::TOTAL_MAX)) ? stree_pkg::TOTAL_MAX
	                                                        : total_q[stree_pkg::OUT_W-1:0];

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stree_pkg::S_CLEAR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == stree_pkg::S_CLEAR) begin
				clr_q <= clr_q + NIDX_W'(1);
			end
			pend_q <= (state_q == stree_pkg::S_QRY) && (rd_lo || rd_hi);
		end
	end

	// Walk pointers, running node value and query accumulator.
	always_ff @(posedge clk) begin
		if (pend_q) begin
			total_q <= total_q + ACC_W'(ram_rdata);
		end
		case (state_q)
			stree_pkg::S_IDLE: begin
				cur_q   <= NIDX_W'(LEAF_BASE + PTR_W'(idx_ext));
				curv_q  <= NODE_W'(leaf_value);
				lo_q    <= LEAF_BASE + PTR_W'(first_ext);
				hi_q    <= LEAF_BASE + PTR_W'(last_clamp) + PTR_W'(1);
				total_q <= '0;
			end
			stree_pkg::S_UPD_LEAF: begin
				cur_q <= cur_q >> 1;
			end
			stree_pkg::S_UPD_UP: begin
				cur_q  <= cur_q >> 1;
				curv_q <= up_sum;
			end
			stree_pkg::S_QRY: begin
				if (rd_lo) begin
					lo_q <= lo_q + PTR_W'(1);
				end else if (rd_hi) begin
					hi_q <= hi_m1;
				end else if (lo_lt_hi) begin
					lo_q <= lo_q >> 1;
					hi_q <= hi_q >> 1;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/segment_tree_range_sum_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_tree_range_sum_core
// Point-update, range-sum segment tree over LEAF_COUNT 16-bit leaves.
// ----------------------------------------------------------------------------
// The tree's 2*LEAF_COUNT partial sums live in one RAM with one write and one
// registered read port, and a sequencer handles one item at a time. After
// reset the block first clears the RAM, one node a cycle, and holds in_ready
// low until every node is cleared. An update writes the leaf and reads its
// sibling, then takes one step per ancestor, each writing the parent sum and
// reading the next sibling. In a query, every node that enters the sum costs
// one pass through the single read port. A finished total waits in an output
// register, so the next item is taken while the result is still unread.
module segment_tree_range_sum_core #(
	parameter int LEAF_COUNT = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        kind,
	input  wire logic [stree_pkg::IDX_W-1:0] leaf_index,
	input  wire logic [stree_pkg::VAL_W-1:0] leaf_value,
	input  wire logic [stree_pkg::IDX_W-1:0] range_first,
	input  wire logic [stree_pkg::IDX_W-1:0] range_last,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [stree_pkg::OUT_W-1:0] range_total
);

	localparam int NIDX_W = $clog2(2 * LEAF_COUNT);
	localparam int NODE_W = stree_pkg::VAL_W + $clog2(LEAF_COUNT);

	stree_pkg::stree_stat_t       stat;
	logic [stree_pkg::OUT_W-1:0]  total;
	logic                         out_free;
	logic                         out_valid_q;
	logic [stree_pkg::OUT_W-1:0]  range_total_q;
	logic                         ram_we;
	logic [NIDX_W-1:0]            ram_waddr;
	logic [NODE_W-1:0]            ram_wdata;
	logic [NIDX_W-1:0]            ram_raddr;
	logic [NODE_W-1:0]            ram_rdata;

	// The output register can take a new total when empty or being drained.
	assign out_free    = !out_valid_q || out_ready;
	assign in_ready    = stat.take_ready;
	assign out_valid   = out_valid_q;
	assign range_total = range_total_q;

	// Node sum memory.
	stree_ram #(
		.WIDTH(NODE_W),
		.DEPTH(2 * LEAF_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Update and query sequencer.
	stree_ctrl #(
		.LEAF_COUNT(LEAF_COUNT),
		.NIDX_W    (NIDX_W),
		.NODE_W    (NODE_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.kind       (kind),
		.leaf_index (leaf_index),
		.leaf_value (leaf_value),
		.range_first(range_first),
		.range_last (range_last),
		.out_free   (out_free),
		.stat       (stat),
		.total      (total),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (stat.result_load) begin
			range_total_q <= total;
		end
	end

`ifndef SYNTH
	// A total is loaded only when the output register has room for it.
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		stat.result_load |-> (!out_valid_q || out_ready))
		else $error("total loaded over an unread result");

	// An update never produces a result item.
	a_update_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (kind == stree_pkg::KIND_UPDATE) && !out_valid)
		|=> !out_valid)
		else $error("result appeared after an update");

	// A query keeps the sequencer busy in the following cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (kind == stree_pkg::KIND_QUERY)) |=> !in_ready)
		else $error("input taken while a query is in progress");
`endif

endmodule

`default_nettype wire
